// File: src/ipv4_udp_icmp_rx_parser_defines.svh
// assertion macros for the ipv4 receive parser
`ifndef IPV4_UDP_ICMP_RX_PARSER_DEFINES_SVH
`define IPV4_UDP_ICMP_RX_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IPRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4 rx parser: same-cycle check failed");

// next-cycle implication, checked outside reset
`define IPRX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4 rx parser: next-cycle check failed");

`endif

// File: src/iprx_pkg.sv
// shared types, constants and the ones'-complement add for the ipv4 receive parser
package iprx_pkg;

  localparam logic [15:0] MASK16     = 16'hffff;
  localparam logic [15:0] MIN_PACKET = 16'd28;
  localparam logic [15:0] UDP_HDR    = 16'd8;
  localparam logic [15:0] IP_HDR     = 16'd20;
  localparam logic [3:0]  IHL_VALUE  = 4'd5;
  localparam logic [3:0]  IP_VERSION = 4'd4;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  PROTO_ICMP = 8'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_LENGTH    = 2'd2,
    ST_CHECKSUM  = 2'd3
  } status_t;

  // ones'-complement 16-bit add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] sum, input logic [15:0] v);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, sum} + {1'b0, v};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// File: src/iprx_if.sv
// handshake channels: packet byte beats, parse results and the mode write
interface iprx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iprx_result_if;
  logic                   valid;
  logic                   ready;
  iprx_pkg::status_t      status;
  logic [31:0]            source_address;
  logic [31:0]            destination_address;
  logic [15:0]            port_or_identifier;
  logic [15:0]            port_or_sequence;
  logic [7:0]             message_type;
  logic [7:0]             message_code;
  logic [15:0]            payload_bytes;
  modport source (output valid, output status, output source_address,
                  output destination_address, output port_or_identifier,
                  output port_or_sequence, output message_type, output message_code,
                  output payload_bytes, input ready);
  modport sink (input valid, input status, input source_address,
                input destination_address, input port_or_identifier,
                input port_or_sequence, input message_type, input message_code,
                input payload_bytes, output ready);
endinterface

interface iprx_cfg_if;
  logic valid;
  logic ready;
  logic protocol_mode;
  modport source (output valid, output protocol_mode, input ready);
  modport sink (input valid, input protocol_mode, output ready);
endinterface

// File: src/ipv4_udp_icmp_rx_parser.sv
// ipv4 receive parser for udp or icmp with header and icmp checksum checks
// The block takes one packet byte per beat at a sustained rate of one beat per
// clock, starting at ipv4 header byte 0, with last_byte marking the final beat.
// Each beat is first captured in an input register; from that register short
// logic updates the byte count, the captured header fields and the two
// ones'-complement sums (header over bytes 0..19, icmp over bytes 20 up to the
// total length, odd final byte padded as high byte). On the last beat it also
// evaluates the checks and loads one result into the output register, where
// it is held until taken. in_bus.ready only drops when a last beat waits for
// an output register that still holds an untaken result. protocol_mode selects
// udp (0) or icmp (1); the value in force when the last beat is processed
// applies. protocol_mode must be written only while idle; the block itself
// has no check for this.
// On any failing status every result field other than status reads zero.
`include "ipv4_udp_icmp_rx_parser_defines.svh"

module ipv4_udp_icmp_rx_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  iprx_byte_if.sink            in_bus,
  iprx_result_if.source        out_bus,
  iprx_cfg_if.sink             cfg_bus
);

  // configuration
  logic mode_r;

  // input register stage
  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;
  logic       a_adv;
  logic       a_fire;

  // per-packet state
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] header_sum_r, header_sum_nxt;
  logic [15:0] message_sum_r, message_sum_nxt;
  logic [7:0]  first_byte_r, first_byte_nxt;
  logic [7:0]  protocol_byte_r, protocol_byte_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [15:0] udp_length_r, udp_length_nxt;
  logic [31:0] source_reg_r, source_reg_nxt;
  logic [31:0] destination_reg_r, destination_reg_nxt;
  logic [15:0] word_a_r, word_a_nxt;
  logic [15:0] word_b_r, word_b_nxt;
  logic [15:0] type_code_r, type_code_nxt;

  // state after taking the current beat, before the end-of-packet clear
  logic [15:0] cnt_u, hsum_u, msum_u, tot_u, udp_u, wa_u, wb_u, tc_u;
  logic [7:0]  fb_u, proto_u;
  logic [31:0] src_u, dst_u;
  logic [15:0] pos;
  logic [15:0] shifted;

  // result evaluation
  iprx_pkg::status_t status_w;
  logic [7:0]        proto_want;
  logic [15:0]       udp_room;

  // output register
  logic                 out_valid_r;
  iprx_pkg::status_t    out_status_r;
  logic [31:0]          out_src_r, out_dst_r;
  logic [15:0]          out_f3_r, out_f4_r, out_plen_r;
  logic [7:0]           out_type_r, out_code_r;

  // handshakes: a last beat can only move on when the result slot frees up
  assign a_adv        = !a_last_r || !out_valid_r || out_bus.ready;
  assign a_fire       = a_valid_r && a_adv;
  assign in_bus.ready = !a_valid_r || a_adv;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      mode_r <= cfg_bus.protocol_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      a_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      a_byte_r <= in_bus.data_byte;
      a_last_r <= in_bus.last_byte;
    end
  end

  // per-beat update of count, sums and captured fields
  always_comb begin
    pos     = byte_count_r;
    shifted = pos[0] ? {8'h00, a_byte_r} : {a_byte_r, 8'h00};

    hsum_u  = header_sum_r;
    msum_u  = message_sum_r;
    fb_u    = first_byte_r;
    proto_u = protocol_byte_r;
    tot_u   = total_length_r;
    udp_u   = udp_length_r;
    src_u   = source_reg_r;
    dst_u   = destination_reg_r;
    wa_u    = word_a_r;
    wb_u    = word_b_r;
    tc_u    = type_code_r;

    // header bytes feed the header sum, then bytes up to total length the icmp sum
    if (pos < iprx_pkg::IP_HDR) begin
      hsum_u = iprx_pkg::oc_add(header_sum_r, shifted);
    end else if (pos < total_length_r) begin
      msum_u = iprx_pkg::oc_add(message_sum_r, shifted);
    end

    priority if (pos == 16'd0) begin
      fb_u = a_byte_r;
    end else if (pos == 16'd2 || pos == 16'd3) begin
      tot_u = {total_length_r[7:0], a_byte_r};
    end else if (pos == 16'd9) begin
      proto_u = a_byte_r;
    end else if (pos >= 16'd12 && pos < 16'd16) begin
      src_u = {source_reg_r[23:0], a_byte_r};
    end else if (pos >= 16'd16 && pos < 16'd20) begin
      dst_u = {destination_reg_r[23:0], a_byte_r};
    end else if (pos == 16'd20 || pos == 16'd21) begin
      tc_u = {type_code_r[7:0], a_byte_r};
    end else if (pos == 16'd22 || pos == 16'd23) begin
      wa_u = {word_a_r[7:0], a_byte_r};
    end else if (pos == 16'd24 || pos == 16'd25) begin
      udp_u = {udp_length_r[7:0], a_byte_r};
    end else if (pos == 16'd26 || pos == 16'd27) begin
      wb_u = {word_b_r[7:0], a_byte_r};
    end else begin
      // payload bytes: nothing captured
    end

    // saturating byte count
    cnt_u = (byte_count_r == iprx_pkg::MASK16) ? byte_count_r : byte_count_r + 16'd1;
  end

  // packet checks, first failing class wins
  always_comb begin
    proto_want = mode_r ? iprx_pkg::PROTO_ICMP : iprx_pkg::PROTO_UDP;
    udp_room   = tot_u - iprx_pkg::IP_HDR;
    priority if (cnt_u < iprx_pkg::MIN_PACKET || fb_u[7:4] != iprx_pkg::IP_VERSION ||
                 fb_u[3:0] != iprx_pkg::IHL_VALUE || proto_u != proto_want) begin
      status_w = iprx_pkg::ST_MALFORMED;
    end else if (tot_u < iprx_pkg::MIN_PACKET || tot_u > cnt_u ||
                 hsum_u != iprx_pkg::MASK16) begin
      status_w = iprx_pkg::ST_LENGTH;
    end else if (!mode_r && (udp_u < iprx_pkg::UDP_HDR || udp_u > udp_room)) begin
      status_w = iprx_pkg::ST_LENGTH;
    end else if (mode_r && msum_u != iprx_pkg::MASK16) begin
      status_w = iprx_pkg::ST_CHECKSUM;
    end else begin
      status_w = iprx_pkg::ST_OK;
    end
  end

  // next state: hold when idle, take the beat, clear after the last beat
  always_comb begin
    byte_count_nxt      = byte_count_r;
    header_sum_nxt      = header_sum_r;
    message_sum_nxt     = message_sum_r;
    first_byte_nxt      = first_byte_r;
    protocol_byte_nxt   = protocol_byte_r;
    total_length_nxt    = total_length_r;
    udp_length_nxt      = udp_length_r;
    source_reg_nxt      = source_reg_r;
    destination_reg_nxt = destination_reg_r;
    word_a_nxt          = word_a_r;
    word_b_nxt          = word_b_r;
    type_code_nxt       = type_code_r;
    if (a_fire) begin
      if (a_last_r) begin
        byte_count_nxt      = '0;
        header_sum_nxt      = '0;
        message_sum_nxt     = '0;
        first_byte_nxt      = '0;
        protocol_byte_nxt   = '0;
        total_length_nxt    = '0;
        udp_length_nxt      = '0;
        source_reg_nxt      = '0;
        destination_reg_nxt = '0;
        word_a_nxt          = '0;
        word_b_nxt          = '0;
        type_code_nxt       = '0;
      end else begin
        byte_count_nxt      = cnt_u;
        header_sum_nxt      = hsum_u;
        message_sum_nxt     = msum_u;
        first_byte_nxt      = fb_u;
        protocol_byte_nxt   = proto_u;
        total_length_nxt    = tot_u;
        udp_length_nxt      = udp_u;
        source_reg_nxt      = src_u;
        destination_reg_nxt = dst_u;
        word_a_nxt          = wa_u;
        word_b_nxt          = wb_u;
        type_code_nxt       = tc_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      header_sum_r      <= '0;
      message_sum_r     <= '0;
      first_byte_r      <= '0;
      protocol_byte_r   <= '0;
      total_length_r    <= '0;
      udp_length_r      <= '0;
      source_reg_r      <= '0;
      destination_reg_r <= '0;
      word_a_r          <= '0;
      word_b_r          <= '0;
      type_code_r       <= '0;
    end else begin
      byte_count_r      <= byte_count_nxt;
      header_sum_r      <= header_sum_nxt;
      message_sum_r     <= message_sum_nxt;
      first_byte_r      <= first_byte_nxt;
      protocol_byte_r   <= protocol_byte_nxt;
      total_length_r    <= total_length_nxt;
      udp_length_r      <= udp_length_nxt;
      source_reg_r      <= source_reg_nxt;
      destination_reg_r <= destination_reg_nxt;
      word_a_r          <= word_a_nxt;
      word_b_r          <= word_b_nxt;
      type_code_r       <= type_code_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_fire && a_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_last_r) begin
      out_status_r <= status_w;
      if (status_w == iprx_pkg::ST_OK) begin
        out_src_r <= src_u;
        out_dst_r <= dst_u;
        if (mode_r) begin
          // icmp: identifier, sequence, type and code
          out_f3_r   <= udp_u;
          out_f4_r   <= wb_u;
          out_type_r <= tc_u[15:8];
          out_code_r <= tc_u[7:0];
          out_plen_r <= tot_u - iprx_pkg::MIN_PACKET;
        end else begin
          // udp: source and destination ports
          out_f3_r   <= tc_u;
          out_f4_r   <= wa_u;
          out_type_r <= '0;
          out_code_r <= '0;
          out_plen_r <= udp_u - iprx_pkg::UDP_HDR;
        end
      end else begin
        out_src_r  <= '0;
        out_dst_r  <= '0;
        out_f3_r   <= '0;
        out_f4_r   <= '0;
        out_type_r <= '0;
        out_code_r <= '0;
        out_plen_r <= '0;
      end
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.status              = out_status_r;
  assign out_bus.source_address      = out_src_r;
  assign out_bus.destination_address = out_dst_r;
  assign out_bus.port_or_identifier  = out_f3_r;
  assign out_bus.port_or_sequence    = out_f4_r;
  assign out_bus.message_type        = out_type_r;
  assign out_bus.message_code        = out_code_r;
  assign out_bus.payload_bytes       = out_plen_r;

  // a processed last beat always leaves a result behind and a fresh packet count
  `IPRX_ASSERT_NXT(a_last_loads_result, clk, rst_n, a_fire && a_last_r, out_valid_r)
  `IPRX_ASSERT_NXT(a_last_clears_count, clk, rst_n, a_fire && a_last_r, byte_count_r == 16'd0)
  // failed packets carry no addresses
  `IPRX_ASSERT_IMP(a_fail_zero_addr, clk, rst_n,
    out_valid_r && out_status_r != iprx_pkg::ST_OK,
    out_src_r == 32'd0 && out_dst_r == 32'd0)

endmodule

// File: tb/tb_ipv4_udp_icmp_rx_parser.sv
// self-checking testbench for the ipv4 udp/icmp receive parser
module tb_ipv4_udp_icmp_rx_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no beat on any channel
  localparam int HOLD_CYCLES    = 400;    // long result-side hold-off

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // one parse result as the block should report it
  typedef struct {
    iprx_pkg::status_t status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] id_or_port;
    logic [15:0] seq_or_port;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] pay_len;
  } parse_result_t;

  logic clk;
  logic rst_n;

  iprx_byte_if   in_bus();
  iprx_result_if out_bus();
  iprx_cfg_if    cfg_bus();

  ipv4_udp_icmp_rx_parser DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // byte beats waiting to be offered, results waiting to come out
  beat_t         tx_beats[$];
  parse_result_t pending_results[$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  calm = 0;            // no idling on either side while set
  bit  hold_request = 0;    // ask the result side for one long hold-off
  bit  hold_used = 0;
  int  hold_left = 0;
  bit  in_took = 0;         // the offered byte beat was taken at the last edge

  // predictor copy of the mode register and of the per-packet state
  logic        cfg_mode   = 1'b0;
  logic [15:0] rx_count   = '0;
  logic [15:0] ip_sum     = '0;
  logic [15:0] icmp_sum   = '0;
  logic [7:0]  ver_ihl    = '0;
  logic [7:0]  proto_seen = '0;
  logic [15:0] ip_total   = '0;
  logic [15:0] udp_len_f  = '0;
  logic [31:0] src_word   = '0;
  logic [31:0] dst_word   = '0;
  logic [15:0] icmp_tc    = '0;
  logic [15:0] bytes22    = '0;
  logic [15:0] bytes26    = '0;

  parse_result_t head;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ones'-complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[15:0]} + {16'd0, s[16]};
    return s[15:0];
  endfunction

  // sum of bytes [from, upto) as big-endian words, odd tail padded low
  function automatic logic [15:0] sum_span(input octets_t p, input int from, input int upto);
    logic [15:0] s;
    int i;
    s = '0;
    for (i = from; i < upto; i++)
      s = fold_add(s, i[0] ? {8'h00, p[i]} : {p[i], 8'h00});
    return s;
  endfunction

  task automatic clear_packet();
    rx_count   = '0;
    ip_sum     = '0;
    icmp_sum   = '0;
    ver_ihl    = '0;
    proto_seen = '0;
    ip_total   = '0;
    udp_len_f  = '0;
    src_word   = '0;
    dst_word   = '0;
    icmp_tc    = '0;
    bytes22    = '0;
    bytes26    = '0;
  endtask

  // advance the packet state by one byte; on the last byte queue the result
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [15:0]   pos;
    logic [15:0]   word;
    logic          icmp;
    parse_result_t r;
    pos  = rx_count;
    word = pos[0] ? {8'h00, b} : {b, 8'h00};

    // header sum over bytes 0..19, message sum up to the ip total length
    if (pos < iprx_pkg::IP_HDR) ip_sum = fold_add(ip_sum, word);
    else if (pos < ip_total) icmp_sum = fold_add(icmp_sum, word);

    if (pos == 0) ver_ihl = b;
    else if (pos == 2 || pos == 3) ip_total = {ip_total[7:0], b};
    else if (pos == 9) proto_seen = b;
    else if (pos >= 12 && pos < 16) src_word = {src_word[23:0], b};
    else if (pos >= 16 && pos < 20) dst_word = {dst_word[23:0], b};
    else if (pos == 20 || pos == 21) icmp_tc = {icmp_tc[7:0], b};
    else if (pos == 22 || pos == 23) bytes22 = {bytes22[7:0], b};
    else if (pos == 24 || pos == 25) udp_len_f = {udp_len_f[7:0], b};
    else if (pos == 26 || pos == 27) bytes26 = {bytes26[7:0], b};

    // count saturates, later bytes of a long packet all sit at the top position
    if (rx_count != iprx_pkg::MASK16) rx_count = rx_count + 16'd1;

    if (last) begin
      icmp          = cfg_mode;
      r.src_addr    = '0;
      r.dst_addr    = '0;
      r.id_or_port  = '0;
      r.seq_or_port = '0;
      r.msg_type    = '0;
      r.msg_code    = '0;
      r.pay_len     = '0;

      // first failing class wins
      if (rx_count < iprx_pkg::MIN_PACKET || ver_ihl[7:4] != iprx_pkg::IP_VERSION ||
          ver_ihl[3:0] != iprx_pkg::IHL_VALUE ||
          proto_seen != (icmp ? iprx_pkg::PROTO_ICMP : iprx_pkg::PROTO_UDP))
        r.status = iprx_pkg::ST_MALFORMED;
      else if (ip_total < iprx_pkg::MIN_PACKET || ip_total > rx_count ||
               ip_sum != iprx_pkg::MASK16)
        r.status = iprx_pkg::ST_LENGTH;
      else if (!icmp && (udp_len_f < iprx_pkg::UDP_HDR ||
                         int'(udp_len_f) > int'(ip_total) - int'(iprx_pkg::IP_HDR)))
        r.status = iprx_pkg::ST_LENGTH;
      else if (icmp && icmp_sum != iprx_pkg::MASK16)
        r.status = iprx_pkg::ST_CHECKSUM;
      else
        r.status = iprx_pkg::ST_OK;

      // a failed packet reports zeros in every other field
      if (r.status == iprx_pkg::ST_OK) begin
        r.src_addr = src_word;
        r.dst_addr = dst_word;
        if (icmp) begin
          r.id_or_port  = udp_len_f;
          r.seq_or_port = bytes26;
          r.msg_type    = icmp_tc[15:8];
          r.msg_code    = icmp_tc[7:0];
          r.pay_len     = ip_total - iprx_pkg::MIN_PACKET;
        end else begin
          r.id_or_port  = icmp_tc;
          r.seq_or_port = bytes22;
          r.pay_len     = udp_len_f - iprx_pkg::UDP_HDR;
        end
      end
      pending_results.push_back(r);
      clear_packet();
    end
  endtask

  task automatic put16(inout octets_t p, input int at, input logic [15:0] v);
    p[at]     = v[15:8];
    p[at + 1] = v[7:0];
  endtask

  // recompute the ipv4 header checksum after touching the header
  task automatic seal_header(inout octets_t p);
    put16(p, 10, 16'h0000);
    put16(p, 10, ~sum_span(p, 0, 20));
  endtask

  // well-formed packet: pay payload bytes, tail extra bytes past the total length
  task automatic build_packet(input logic icmp, input int pay, input int tail,
                              output octets_t p);
    logic [15:0] tot;
    tot = 16'(28 + pay);
    p = {};
    p.push_back({iprx_pkg::IP_VERSION, iprx_pkg::IHL_VALUE});
    p.push_back(8'($urandom));                 // tos
    p.push_back(tot[15:8]);
    p.push_back(tot[7:0]);
    repeat (5) p.push_back(8'($urandom));      // id, flags, fragment, ttl
    p.push_back(icmp ? iprx_pkg::PROTO_ICMP : iprx_pkg::PROTO_UDP);
    p.push_back(8'h00);
    p.push_back(8'h00);
    repeat (16 + pay + tail) p.push_back(8'($urandom));
    if (icmp) begin
      put16(p, 22, 16'h0000);
      put16(p, 22, ~sum_span(p, 20, int'(tot)));
    end else begin
      put16(p, 24, 16'(8 + pay));
    end
    seal_header(p);
  endtask

  // queue bytes [from, upto); the final one carries the last flag if close
  task automatic queue_beats(input octets_t p, input int from, input int upto, input bit close);
    beat_t bt;
    int i;
    for (i = from; i < upto; i++) begin
      bt.data = p[i];
      bt.last = close && (i == upto - 1);
      tx_beats.push_back(bt);
    end
  endtask

  // mostly good packets of the selected protocol, the rest broken or plain noise
  task automatic random_packet(input logic m);
    octets_t p;
    int kind;
    int pay;
    kind = $urandom_range(0, 99);
    pay  = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
    build_packet((kind >= 60 && kind < 65) ? !m : m, pay,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, p);
    if (kind >= 65 && kind < 72) begin
      p[$urandom_range(0, p.size() - 1)] = 8'($urandom);
    end else if (kind >= 72 && kind < 78) begin
      repeat ($urandom_range(1, p.size() - 1)) void'(p.pop_back());
    end else if (kind >= 78 && kind < 84) begin
      // bad header field behind a correct header checksum
      case ($urandom_range(0, 3))
        0: p[0] = {4'($urandom), iprx_pkg::IHL_VALUE};
        1: p[0] = {iprx_pkg::IP_VERSION, 4'($urandom)};
        2: put16(p, 2, 16'($urandom_range(0, p.size() + 4)));
        default: p[9] = 8'($urandom);
      endcase
      seal_header(p);
    end else if (kind >= 84 && kind < 88) begin
      put16(p, 24, 16'($urandom_range(0, pay + 16)));
    end else if (kind >= 88 && kind < 92) begin
      p[22 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end else if (kind >= 92) begin
      p = {};
      repeat ($urandom_range(1, 40)) p.push_back(8'($urandom));
    end
    queue_beats(p, 0, p.size(), 1);
  endtask

  // wait until every byte is taken and every result is out, then let the pipe empty
  task automatic settle();
    while (tx_beats.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.protocol_mode <= m;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_mode = m;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // byte driver: offer the head of the queue, idling now and then between beats
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (tx_beats.size() != 0 &&
                 ((in_bus.valid && !in_took) || calm || $urandom_range(0, 99) >= 16)) begin
      in_bus.valid     <= 1'b1;
      in_bus.data_byte <= tx_beats[0].data;
      in_bus.last_byte <= tx_beats[0].last;
    end else begin
      in_bus.valid <= 1'b0;
    end
  end

  // a byte beat taken by the block feeds the predictor
  always @(posedge clk) begin
    in_took = rst_n && in_bus.valid && in_bus.ready;
    if (in_took) begin
      absorb_byte(in_bus.data_byte, in_bus.last_byte);
      void'(tx_beats.pop_front());
    end
  end

  // result side ready: one long hold-off on request, otherwise random stalls
  always @(negedge clk) begin
    if (hold_request && !hold_used) begin
      hold_used     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor: every result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual status %0d",
                 $time, out_bus.status);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        compare_field("status", 32'(head.status), 32'(out_bus.status));
        compare_field("source_address", head.src_addr, out_bus.source_address);
        compare_field("destination_address", head.dst_addr, out_bus.destination_address);
        compare_field("port_or_identifier", 32'(head.id_or_port),
                      32'(out_bus.port_or_identifier));
        compare_field("port_or_sequence", 32'(head.seq_or_port),
                      32'(out_bus.port_or_sequence));
        compare_field("message_type", 32'(head.msg_type), 32'(out_bus.message_type));
        compare_field("message_code", 32'(head.msg_code), 32'(out_bus.message_code));
        compare_field("payload_bytes", 32'(head.pay_len), 32'(out_bus.payload_bytes));
      end
    end
  end

  // watchdog: too long with no beat on any channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
      $display("** ipv4_udp_icmp_rx_parser: FAILED **");
      $finish;
    end
  end

  // stimulus: directed cases, random phases across mode writes, back-pressure
  initial begin
    octets_t p;
    octets_t carry;
    int      carry_at;
    int      ph;
    logic    modes[6];

    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.data_byte      = 8'h00;
    in_bus.last_byte      = 1'b0;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.protocol_mode = 1'b0;
    carry_at              = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // udp mode out of reset
    build_packet(1'b0, 0, 0, p);                  // minimal udp, zero payload
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 5, 3, p);                  // bytes past the total length
    queue_beats(p, 0, p.size(), 1);
    p = {8'hff};                                  // one-byte packet
    queue_beats(p, 0, 1, 1);
    build_packet(1'b0, 0, 0, p);                  // one byte short of minimum
    queue_beats(p, 0, 27, 1);
    build_packet(1'b1, 4, 0, p);                  // icmp while parsing udp
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // wrong version
    p[0] = 8'h65;
    seal_header(p);
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // header length not five words
    p[0] = 8'h46;
    seal_header(p);
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // header checksum broken
    p[8] ^= 8'h01;
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // total length under minimum
    put16(p, 2, 16'd27);
    seal_header(p);
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // total length beyond what arrived
    put16(p, 2, 16'd31);
    seal_header(p);
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // udp length under header size
    put16(p, 24, 16'd7);
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 2, 0, p);                  // udp length past ip payload
    put16(p, 24, 16'd11);
    queue_beats(p, 0, p.size(), 1);

    settle();
    write_mode(1'b1);
    build_packet(1'b1, 0, 0, p);                  // minimal icmp
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b1, 7, 2, p);                  // odd message length, padded byte
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b1, 6, 0, p);                  // icmp checksum broken
    p[27] ^= 8'h80;
    queue_beats(p, 0, p.size(), 1);
    build_packet(1'b0, 6, 0, p);                  // udp while parsing icmp
    queue_beats(p, 0, p.size(), 1);

    // mode flips while a packet is half received
    build_packet(1'b0, 9, 0, p);
    queue_beats(p, 0, 14, 0);
    settle();
    write_mode(1'b0);
    queue_beats(p, 14, p.size(), 1);

    // random phases, one of them with no idling at all
    foreach (modes[i]) modes[i] = 1'($urandom_range(0, 1));
    for (ph = 0; ph < 6; ph++) begin
      settle();
      calm = (ph == 2);
      write_mode(modes[ph]);
      if (carry_at != 0) begin
        queue_beats(carry, carry_at, carry.size(), 1);
        carry_at = 0;
      end
      repeat (2) random_packet(modes[ph]);
      // sometimes leave a packet open across the next mode write
      if (ph < 5 && $urandom_range(0, 1) == 1) begin
        build_packet(modes[ph + 1], $urandom_range(0, 24), 0, carry);
        carry_at = $urandom_range(1, 27);
        queue_beats(carry, 0, carry_at, 0);
      end
    end
    settle();
    calm = 0;

    // result side holds off while short packets keep coming, input must stall
    hold_request = 1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 1) begin
        p = {8'($urandom)};
        queue_beats(p, 0, 1, 1);
      end else begin
        build_packet(modes[5], 0, 0, p);
        queue_beats(p, 0, p.size(), 1);
      end
    end
    settle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** ipv4_udp_icmp_rx_parser: PASSED **");
    else
      $display("** ipv4_udp_icmp_rx_parser: FAILED **");
    $finish;
  end

endmodule
